>>> hdl/ssr_pkg.sv
`timescale 1ns / 1ps

package ssr_pkg;

   localparam int SETS              = 2048;
   localparam int WAYS              = 16;
   localparam int SIG_TABLE_ENTRIES = 16384;

   localparam int SET_W    = $clog2(SETS);
   localparam int SIG_W    = $clog2(SIG_TABLE_ENTRIES);
   localparam int RRPV_W   = 3;
   localparam int CTR_W    = 2;
   localparam int WAY_IN_W = 4;
   localparam int VICTIM_W = 4;
   localparam int ACC_W    = 2;
   localparam int PC_W     = 48;

   localparam int CLEAR_CYCLES = (SIG_TABLE_ENTRIES > SETS) ? SIG_TABLE_ENTRIES : SETS;
   localparam int CLR_W        = $clog2(CLEAR_CYCLES);

   localparam logic [RRPV_W-1:0] RRPV_DISTANT = 3'd7;
   localparam logic [RRPV_W-1:0] RRPV_LONG    = RRPV_DISTANT - 3'd3;
   localparam logic [RRPV_W-1:0] RRPV_NEAR    = 3'd0;
   localparam logic [CTR_W-1:0]  CTR_MAX      = 2'd3;
   localparam logic [CTR_W-1:0]  CTR_MIN      = 2'd0;

   localparam logic OP_VICTIM = 1'b0;
   localparam logic OP_UPDATE = 1'b1;

   localparam logic [ACC_W-1:0] ACC_DEMAND    = 2'd0;
   localparam logic [ACC_W-1:0] ACC_PREFETCH  = 2'd1;
   localparam logic [ACC_W-1:0] ACC_WRITEBACK = 2'd2;

   typedef struct packed {
      logic [RRPV_W-1:0] rrpv;
      logic              reused;
      logic              prefetched;
      logic [SIG_W-1:0]  signature;
   } line_type;

   localparam line_type LINE_RESET = '{
      rrpv: RRPV_DISTANT, reused: 1'b0, prefetched: 1'b0, signature: '0};

   typedef struct packed {
      logic clear;
      logic capture;
      logic latch_new;
      logic read_old;
      logic write_victim;
      logic write_update;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic is_victim;
      logic rsp_free;
   } status_type;

endpackage

>>> hdl/ship_srrip_replacement.sv
`timescale 1ns / 1ps
// Victim request: the row is read on accept, then the result register is loaded in ROW
// once no held result is stalled by rsp_stall; a new request is taken only back in IDLE.
// Update request: row read, then counter read, then row and counter write.
// The cost is set by the row memory read and the dependent counter memory read.
// Reset: synchronous, active high; then a clearing pass sweeps all 16384 counter entries
// and 2048 line rows with req_stall held high before the first accept.

module ship_srrip_replacement #(
   parameter int WAYS = ssr_pkg::WAYS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_opcode,
   input  logic [ssr_pkg::SET_W-1:0]     req_set_index,
   input  logic [ssr_pkg::WAY_IN_W-1:0]  req_way,
   input  logic [ssr_pkg::ACC_W-1:0]     req_access_type,
   input  logic                          req_hit,
   input  logic [ssr_pkg::PC_W-1:0]      req_pc,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ssr_pkg::VICTIM_W-1:0]  rsp_victim_way
);

   ssr_pkg::cmd_type    cmd;
   ssr_pkg::status_type status;

   ssr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ssr_datapath #(
      .WAYS (WAYS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_opcode      (req_opcode),
      .req_set_index   (req_set_index),
      .req_way         (req_way),
      .req_access_type (req_access_type),
      .req_hit         (req_hit),
      .req_pc          (req_pc),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_victim_way  (rsp_victim_way)
   );

endmodule

>>> hdl/ssr_ram.sv
`timescale 1ns / 1ps

module ssr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

>>> hdl/ssr_ctrl.sv
`timescale 1ns / 1ps

module ssr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  ssr_pkg::status_type status,
   output ssr_pkg::cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_ROW   = 4'b0100,
      ST_CTR   = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_ROW;
            end
         end
         ST_ROW: begin
            if (status.is_victim) begin
               if (status.rsp_free) begin
                  cmd.write_victim = 1'b1;
                  cmd.load_rsp     = 1'b1;
                  state_in         = ST_IDLE;
               end
            end else begin
               cmd.latch_new = 1'b1;
               cmd.read_old  = 1'b1;
               state_in      = ST_CTR;
            end
         end
         ST_CTR: begin
            cmd.write_update = 1'b1;
            state_in         = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   a_accept_to_row: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_ROW))
      else $error("accepted beat did not start a row read");

   a_update_to_ctr: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROW && !status.is_victim) |=> (state_ff == ST_CTR))
      else $error("update did not reach the counter step");

endmodule

>>> hdl/ssr_datapath.sv
`timescale 1ns / 1ps

module ssr_datapath #(
   parameter int WAYS = ssr_pkg::WAYS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ssr_pkg::cmd_type                    cmd,
   output ssr_pkg::status_type                 status,
   input  logic                                req_opcode,
   input  logic [ssr_pkg::SET_W-1:0]           req_set_index,
   input  logic [ssr_pkg::WAY_IN_W-1:0]        req_way,
   input  logic [ssr_pkg::ACC_W-1:0]           req_access_type,
   input  logic                                req_hit,
   input  logic [ssr_pkg::PC_W-1:0]            req_pc,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [ssr_pkg::VICTIM_W-1:0]        rsp_victim_way
);

   localparam int WAY_BITS = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int ROW_W    = WAYS * $bits(ssr_pkg::line_type);
   localparam int LEVELS   = 1 << ssr_pkg::RRPV_W;

   logic                              op_ff;
   logic [ssr_pkg::SET_W-1:0]         set_ff;
   logic [ssr_pkg::WAY_IN_W-1:0]      way_ff;
   logic [ssr_pkg::ACC_W-1:0]         acc_ff;
   logic                              hit_ff;
   logic [ssr_pkg::SIG_W-1:0]         newsig_ff;
   logic [ssr_pkg::CTR_W-1:0]         newctr_ff;
   logic [ssr_pkg::CLR_W-1:0]         clr_ff;
   logic                              rsp_valid_ff;
   logic [ssr_pkg::VICTIM_W-1:0]      rsp_way_ff;

   logic [ssr_pkg::SIG_W-1:0]         req_sig;
   logic [ROW_W-1:0]                  row_rdata;
   ssr_pkg::line_type [WAYS-1:0]      row_q;
   ssr_pkg::line_type [WAYS-1:0]      aged_row;
   ssr_pkg::line_type [WAYS-1:0]      upd_row;
   ssr_pkg::line_type [WAYS-1:0]      reset_row;
   ssr_pkg::line_type                 line;
   ssr_pkg::line_type                 upd_line;
   logic [LEVELS-1:0]                 level_seen;
   logic [ssr_pkg::RRPV_W-1:0]        top;
   logic [ssr_pkg::RRPV_W-1:0]        age_add;
   logic [WAY_BITS-1:0]               vic;
   logic [WAY_BITS-1:0]               idx;
   logic                              way_ok;
   logic [ssr_pkg::CTR_W-1:0]         ctr_rdata;
   logic [ssr_pkg::CTR_W-1:0]         ctr_dec;
   logic [ssr_pkg::CTR_W-1:0]         ctr_inc;
   logic [ssr_pkg::CTR_W-1:0]         ctr_new_eff;
   logic [ssr_pkg::CTR_W-1:0]         ctr_upd;
   logic                              ctr_upd_en;
   logic                              rsp_free;

   logic                              row_wr_en;
   logic [ssr_pkg::SET_W-1:0]         row_wr_addr;
   logic [ROW_W-1:0]                  row_wr_data;
   logic                              ctr_wr_en;
   logic [ssr_pkg::SIG_W-1:0]         ctr_wr_addr;
   logic [ssr_pkg::CTR_W-1:0]         ctr_wr_data;
   logic                              ctr_rd_en;
   logic [ssr_pkg::SIG_W-1:0]         ctr_rd_addr;

   assign req_sig = ssr_pkg::SIG_W'(req_pc)
                  + ssr_pkg::SIG_W'(req_access_type == ssr_pkg::ACC_PREFETCH);
   assign row_q   = row_rdata;
   assign idx     = WAY_BITS'(way_ff);
   assign way_ok  = int'(way_ff) < WAYS;
   assign line    = row_q[idx];

   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         reset_row[w] = ssr_pkg::LINE_RESET;
      end
   end

   // victim search: age by the gap to distant, pick lowest way at the top value
   always_comb begin
      level_seen = '0;
      for (int w = 0; w < WAYS; w++) begin
         level_seen[row_q[w].rrpv] = 1'b1;
      end
      top = '0;
      for (int v = 0; v < LEVELS; v++) begin
         if (level_seen[v]) begin
            top = ssr_pkg::RRPV_W'(v);
         end
      end
      age_add = ssr_pkg::RRPV_DISTANT - top;
      vic = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (row_q[w].rrpv == top) begin
            vic = WAY_BITS'(w);
         end
      end
      aged_row = row_q;
      for (int w = 0; w < WAYS; w++) begin
         aged_row[w].rrpv = row_q[w].rrpv + age_add;
      end
   end

   // line update after hit, fill or writeback
   always_comb begin
      ctr_dec = (!line.reused && ctr_rdata != ssr_pkg::CTR_MIN) ? ctr_rdata - 1'b1
                                                                : ctr_rdata;
      ctr_inc = (ctr_rdata == ssr_pkg::CTR_MAX) ? ssr_pkg::CTR_MAX : ctr_rdata + 1'b1;
      ctr_new_eff = (line.signature == newsig_ff) ? ctr_dec : newctr_ff;
      upd_line   = line;
      ctr_upd_en = 1'b0;
      ctr_upd    = ctr_dec;
      priority if (acc_ff == ssr_pkg::ACC_WRITEBACK) begin
         upd_line.rrpv = ssr_pkg::RRPV_DISTANT;
      end else if (hit_ff) begin
         if (acc_ff == ssr_pkg::ACC_PREFETCH && !line.prefetched) begin
            upd_line.prefetched = 1'b1;
            upd_line.rrpv       = ssr_pkg::RRPV_DISTANT;
         end else begin
            upd_line.rrpv       = ssr_pkg::RRPV_NEAR;
            upd_line.reused     = 1'b1;
            upd_line.prefetched = 1'b0;
            ctr_upd_en          = 1'b1;
            ctr_upd             = ctr_inc;
         end
      end else begin
         ctr_upd_en          = 1'b1;
         ctr_upd             = ctr_dec;
         upd_line.reused     = 1'b0;
         upd_line.signature  = newsig_ff;
         upd_line.rrpv       = (ctr_new_eff == ssr_pkg::CTR_MIN) ? ssr_pkg::RRPV_DISTANT
                                                                 : ssr_pkg::RRPV_LONG;
      end
      upd_row      = row_q;
      upd_row[idx] = upd_line;
   end

   always_comb begin
      row_wr_en   = 1'b0;
      row_wr_addr = set_ff;
      row_wr_data = upd_row;
      ctr_wr_en   = 1'b0;
      ctr_wr_addr = line.signature;
      ctr_wr_data = ctr_upd;
      priority if (cmd.clear) begin
         row_wr_en   = int'(clr_ff) < ssr_pkg::SETS;
         row_wr_addr = clr_ff[ssr_pkg::SET_W-1:0];
         row_wr_data = reset_row;
         ctr_wr_en   = int'(clr_ff) < ssr_pkg::SIG_TABLE_ENTRIES;
         ctr_wr_addr = clr_ff[ssr_pkg::SIG_W-1:0];
         ctr_wr_data = ssr_pkg::CTR_MAX;
      end else if (cmd.write_victim) begin
         row_wr_en   = 1'b1;
         row_wr_data = aged_row;
      end else if (cmd.write_update) begin
         row_wr_en = way_ok;
         ctr_wr_en = way_ok && ctr_upd_en;
      end else begin
         row_wr_en = 1'b0;
      end
   end

   assign ctr_rd_en   = cmd.capture || cmd.read_old;
   assign ctr_rd_addr = cmd.capture ? req_sig : line.signature;

   ssr_ram #(
      .WIDTH (ROW_W),
      .DEPTH (ssr_pkg::SETS)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (row_wr_en),
      .wr_addr (row_wr_addr),
      .wr_data (row_wr_data),
      .rd_en   (cmd.capture),
      .rd_addr (req_set_index),
      .rd_data (row_rdata)
   );

   ssr_ram #(
      .WIDTH (ssr_pkg::CTR_W),
      .DEPTH (ssr_pkg::SIG_TABLE_ENTRIES)
   ) u_ctr_ram (
      .clock   (clock),
      .wr_en   (ctr_wr_en),
      .wr_addr (ctr_wr_addr),
      .wr_data (ctr_wr_data),
      .rd_en   (ctr_rd_en),
      .rd_addr (ctr_rd_addr),
      .rd_data (ctr_rdata)
   );

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff     <= req_opcode;
         set_ff    <= req_set_index;
         way_ff    <= req_way;
         acc_ff    <= req_access_type;
         hit_ff    <= req_hit;
         newsig_ff <= req_sig;
      end
      if (cmd.latch_new) begin
         newctr_ff <= ctr_rdata;
      end
      if (cmd.load_rsp) begin
         rsp_way_ff <= ssr_pkg::VICTIM_W'(vic);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_free          = !rsp_valid_ff || !rsp_stall;
   assign status.clear_last = (clr_ff == ssr_pkg::CLR_W'(ssr_pkg::CLEAR_CYCLES - 1));
   assign status.is_victim  = (op_ff == ssr_pkg::OP_VICTIM);
   assign status.rsp_free   = rsp_free;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_victim_way    = rsp_way_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> rsp_free)
      else $error("result register overwritten while held");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> rsp_valid_ff)
      else $error("loaded result not presented");

   a_victim_distant: assert property (@(posedge clock) disable iff (reset)
      cmd.write_victim |-> (aged_row[vic].rrpv == ssr_pkg::RRPV_DISTANT))
      else $error("chosen victim not at distant value after aging");

endmodule

>>> sim/ship_srrip_replacement_tb.sv
`timescale 1ns / 1ps

module ship_srrip_replacement_tb;

   localparam int LINES = ssr_pkg::SETS * ssr_pkg::WAYS;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int DRAIN_CYCLES = 20;
   localparam logic [ssr_pkg::ACC_W-1:0] ACC_OTHER = 2'd3;

   localparam logic [ssr_pkg::PC_W-1:0] PC_A = 48'h0000_1234_5678;
   localparam logic [ssr_pkg::PC_W-1:0] PC_B = 48'h8A5C_0F0F_1E2D;
   localparam logic [ssr_pkg::PC_W-1:0] PC_MAX = 48'hFFFF_FFFF_FFFF;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic                          req_opcode;
   logic [ssr_pkg::SET_W-1:0]     req_set_index;
   logic [ssr_pkg::WAY_IN_W-1:0]  req_way;
   logic [ssr_pkg::ACC_W-1:0]     req_access_type;
   logic                          req_hit;
   logic [ssr_pkg::PC_W-1:0]      req_pc;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic [ssr_pkg::VICTIM_W-1:0]  rsp_victim_way;

   logic [ssr_pkg::RRPV_W-1:0]   line_rrpv [LINES];
   logic                         line_reused [LINES];
   logic                         line_prefetched [LINES];
   logic [ssr_pkg::SIG_W-1:0]    line_sig [LINES];
   logic [ssr_pkg::CTR_W-1:0]    sig_ctr [ssr_pkg::SIG_TABLE_ENTRIES];

   logic [ssr_pkg::VICTIM_W-1:0] expected_victims [$];
   logic [ssr_pkg::VICTIM_W-1:0] last_victim;
   int                           error_count = 0;
   int                           items_sent = 0;
   int                           holdoff_requests = 0;
   int                           cycle_count;
   bit                           no_idle = 0;

   ship_srrip_replacement dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_set_index   (req_set_index),
      .req_way         (req_way),
      .req_access_type (req_access_type),
      .req_hit         (req_hit),
      .req_pc          (req_pc),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_victim_way  (rsp_victim_way)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic void clear_replacement_state();
      for (int i = 0; i < LINES; i++) begin
         line_rrpv[i] = ssr_pkg::RRPV_DISTANT;
         line_reused[i] = 1'b0;
         line_prefetched[i] = 1'b0;
         line_sig[i] = '0;
      end
      for (int i = 0; i < ssr_pkg::SIG_TABLE_ENTRIES; i++) begin
         sig_ctr[i] = ssr_pkg::CTR_MAX;
      end
   endfunction

   function automatic logic [ssr_pkg::VICTIM_W-1:0] age_and_pick(int base);
      logic [ssr_pkg::RRPV_W-1:0]   top;
      logic [ssr_pkg::RRPV_W-1:0]   lift;
      logic [ssr_pkg::VICTIM_W-1:0] pick;
      bit                           found;
      top = ssr_pkg::RRPV_NEAR;
      for (int w = 0; w < ssr_pkg::WAYS; w++) begin
         if (line_rrpv[base + w] > top) top = line_rrpv[base + w];
      end
      lift = ssr_pkg::RRPV_DISTANT - top;
      for (int w = 0; w < ssr_pkg::WAYS; w++) begin
         line_rrpv[base + w] = line_rrpv[base + w] + lift;
      end
      pick = '0;
      found = 0;
      for (int w = 0; w < ssr_pkg::WAYS; w++) begin
         if (!found && line_rrpv[base + w] == ssr_pkg::RRPV_DISTANT) begin
            pick = ssr_pkg::VICTIM_W'(w);
            found = 1;
         end
      end
      return pick;
   endfunction

   function automatic void train_line(int idx, logic [ssr_pkg::ACC_W-1:0] acc, logic hit,
                                      logic [ssr_pkg::PC_W-1:0] pc);
      logic [ssr_pkg::SIG_W-1:0] old_sig;
      logic [ssr_pkg::SIG_W-1:0] new_sig;
      logic                      is_pf;
      is_pf = (acc == ssr_pkg::ACC_PREFETCH);
      old_sig = line_sig[idx];
      if (acc == ssr_pkg::ACC_WRITEBACK) begin
         line_rrpv[idx] = ssr_pkg::RRPV_DISTANT;
      end else if (hit) begin
         if (is_pf && !line_prefetched[idx]) begin
            line_prefetched[idx] = 1'b1;
            line_rrpv[idx] = ssr_pkg::RRPV_DISTANT;
         end else begin
            line_prefetched[idx] = 1'b0;
            line_rrpv[idx] = ssr_pkg::RRPV_NEAR;
            line_reused[idx] = 1'b1;
            if (sig_ctr[old_sig] != ssr_pkg::CTR_MAX) begin
               sig_ctr[old_sig] = sig_ctr[old_sig] + 1'b1;
            end
         end
      end else begin
         if (!line_reused[idx] && sig_ctr[old_sig] != ssr_pkg::CTR_MIN) begin
            sig_ctr[old_sig] = sig_ctr[old_sig] - 1'b1;
         end
         line_reused[idx] = 1'b0;
         new_sig = pc[ssr_pkg::SIG_W-1:0] + ssr_pkg::SIG_W'(is_pf);
         line_sig[idx] = new_sig;
         line_rrpv[idx] = (sig_ctr[new_sig] == ssr_pkg::CTR_MIN) ? ssr_pkg::RRPV_DISTANT
                                                                  : ssr_pkg::RRPV_LONG;
      end
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [ssr_pkg::PC_W-1:0] rand_pc();
      return ssr_pkg::PC_W'({$urandom, $urandom});
   endfunction

   task automatic report_error(string msg);
      $display("ERROR @%0t: %s", $time, msg);
      error_count++;
   endtask

   task automatic send_req(logic op, logic [ssr_pkg::SET_W-1:0] set_idx,
                           logic [ssr_pkg::WAY_IN_W-1:0] way,
                           logic [ssr_pkg::ACC_W-1:0] acc, logic hit,
                           logic [ssr_pkg::PC_W-1:0] pc);
      int gap;
      int base;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_opcode <= op;
      req_set_index <= set_idx;
      req_way <= way;
      req_access_type <= acc;
      req_hit <= hit;
      req_pc <= pc;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      base = (int'(set_idx) % ssr_pkg::SETS) * ssr_pkg::WAYS;
      if (op == ssr_pkg::OP_VICTIM) begin
         last_victim = age_and_pick(base);
         expected_victims.push_back(last_victim);
      end else if (int'(way) < ssr_pkg::WAYS) begin
         train_line(base + int'(way), acc, hit, pc);
      end
      items_sent++;
   endtask

   task automatic ask_victim(logic [ssr_pkg::SET_W-1:0] set_idx);
      send_req(ssr_pkg::OP_VICTIM, set_idx, ssr_pkg::WAY_IN_W'($urandom),
               ssr_pkg::ACC_W'($urandom), 1'($urandom), rand_pc());
   endtask

   task automatic test_reset_state();
      ask_victim('0);
      ask_victim('1);
   endtask

   task automatic test_update_rules();
      send_req(ssr_pkg::OP_UPDATE, '0, 4'd3, ssr_pkg::ACC_DEMAND, 1'b0, PC_A);
      send_req(ssr_pkg::OP_UPDATE, '0, 4'd3, ssr_pkg::ACC_DEMAND, 1'b1, PC_B);
      send_req(ssr_pkg::OP_UPDATE, '0, 4'd5, ssr_pkg::ACC_PREFETCH, 1'b1, PC_B);
      send_req(ssr_pkg::OP_UPDATE, '0, 4'd5, ssr_pkg::ACC_PREFETCH, 1'b1, PC_A);
      send_req(ssr_pkg::OP_UPDATE, '0, 4'd3, ssr_pkg::ACC_WRITEBACK, 1'b1, PC_A);
      send_req(ssr_pkg::OP_UPDATE, '0, 4'd6, ssr_pkg::ACC_WRITEBACK, 1'b0, PC_B);
      send_req(ssr_pkg::OP_UPDATE, '0, 4'd15, ACC_OTHER, 1'b0, PC_MAX);
      send_req(ssr_pkg::OP_UPDATE, '0, 4'd14, ssr_pkg::ACC_PREFETCH, 1'b0, PC_MAX);
      ask_victim('0);
   endtask

   task automatic test_counter_training();
      repeat (4) send_req(ssr_pkg::OP_UPDATE, '1, 4'd15, ssr_pkg::ACC_DEMAND, 1'b0, PC_B);
      send_req(ssr_pkg::OP_UPDATE, '1, 4'd0, ssr_pkg::ACC_DEMAND, 1'b0, PC_B);
      ask_victim('1);
      send_req(ssr_pkg::OP_UPDATE, '1, 4'd15, ACC_OTHER, 1'b1, PC_A);
      send_req(ssr_pkg::OP_UPDATE, '1, 4'd15, ssr_pkg::ACC_PREFETCH, 1'b0, PC_B - 1'b1);
      ask_victim('1);
   endtask

   task automatic test_result_backpressure();
      no_idle = 1;
      holdoff_requests++;
      for (int i = 0; i < 20; i++) begin
         ask_victim(ssr_pkg::SET_W'(i % 3));
         send_req(ssr_pkg::OP_UPDATE, ssr_pkg::SET_W'(i % 3), last_victim,
                  ssr_pkg::ACC_DEMAND, 1'b0, PC_A);
      end
      no_idle = 0;
   endtask

   task automatic test_random_traffic(int count);
      logic [ssr_pkg::SET_W-1:0]    set_pool [8];
      logic [ssr_pkg::PC_W-1:0]     pc_pool [10];
      logic [ssr_pkg::SET_W-1:0]    s;
      logic [ssr_pkg::VICTIM_W-1:0] v;
      logic [ssr_pkg::ACC_W-1:0]    acc;
      logic [ssr_pkg::PC_W-1:0]     pc;
      int                           stop_at;
      int                           r;
      set_pool[0] = '0;
      set_pool[1] = '1;
      set_pool[2] = ssr_pkg::SET_W'(1 << (ssr_pkg::SET_W - 1));
      for (int i = 3; i < 8; i++) set_pool[i] = ssr_pkg::SET_W'($urandom);
      for (int i = 0; i < 10; i++) pc_pool[i] = rand_pc();
      pc_pool[9] = {~pc_pool[8][ssr_pkg::PC_W-1:ssr_pkg::SIG_W],
                    pc_pool[8][ssr_pkg::SIG_W-1:0]};
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         if ($urandom_range(0, 39) == 0) no_idle = !no_idle;
         r = $urandom_range(0, 99);
         if (r < 75) begin
            s = set_pool[$urandom_range(0, 7)];
            ask_victim(s);
            v = last_victim;
            r = $urandom_range(0, 9);
            acc = (r < 5) ? ssr_pkg::ACC_DEMAND : (r < 8) ? ssr_pkg::ACC_PREFETCH
                : (r < 9) ? ACC_OTHER : ssr_pkg::ACC_WRITEBACK;
            pc = ($urandom_range(0, 99) < 85) ? pc_pool[$urandom_range(0, 9)] : rand_pc();
            send_req(ssr_pkg::OP_UPDATE, s, v, acc, 1'b0, pc);
            repeat ($urandom_range(0, 4)) begin
               send_req(ssr_pkg::OP_UPDATE, s,
                        ($urandom_range(0, 9) < 7) ? v : ssr_pkg::WAY_IN_W'($urandom),
                        ssr_pkg::ACC_W'($urandom), ($urandom_range(0, 9) != 0),
                        pc_pool[$urandom_range(0, 9)]);
            end
         end else begin
            s = ($urandom_range(0, 1) == 0) ? set_pool[$urandom_range(0, 7)]
                                             : ssr_pkg::SET_W'($urandom);
            send_req(1'($urandom), s, ssr_pkg::WAY_IN_W'($urandom),
                     ssr_pkg::ACC_W'($urandom), 1'($urandom), rand_pc());
         end
      end
      no_idle = 0;
   endtask

   initial begin : rsp_side
      int stall_left;
      int hold_left;
      int holdoffs_seen;
      stall_left = 0;
      hold_left = 0;
      holdoffs_seen = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (holdoff_requests != holdoffs_seen) begin
            holdoffs_seen = holdoff_requests;
            hold_left = HOLDOFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (no_idle) begin
            stall_left = 0;
            rsp_stall <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            stall_left = pick_gap();
            if (stall_left > 0) begin
               stall_left--;
               rsp_stall <= 1'b1;
            end else begin
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : check_victims
      logic [ssr_pkg::VICTIM_W-1:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_victims.size() == 0) begin
            report_error($sformatf("victim beat %0d with nothing expected", rsp_victim_way));
         end else begin
            want = expected_victims.pop_front();
            if (rsp_victim_way !== want) begin
               report_error($sformatf("victim_way got %0d want %0d", rsp_victim_way, want));
            end
         end
      end
   end

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_opcode <= ssr_pkg::OP_VICTIM;
      req_set_index <= '0;
      req_way <= '0;
      req_access_type <= ssr_pkg::ACC_DEMAND;
      req_hit <= 1'b0;
      req_pc <= '0;
      clear_replacement_state();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_update_rules();
      test_counter_training();
      test_result_backpressure();
      test_random_traffic(1800);

      req_valid <= 1'b0;
      while (expected_victims.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

>>> sim.f
hdl/ssr_pkg.sv
hdl/ssr_ram.sv
hdl/ssr_ctrl.sv
hdl/ssr_datapath.sv
hdl/ship_srrip_replacement.sv
sim/ship_srrip_replacement_tb.sv
